[rtl/mfpe_pkg.sv]
// Shared types, widths and constants of the mono framebuffer pixel expander.
`default_nettype none

package mfpe_pkg;

   // Screen geometry and source memory layout
   localparam int SCREEN_WIDTH  = 1024;
   localparam int SCREEN_HEIGHT = 800;
   localparam int SOURCE_PITCH  = 1024;

   // Field widths
   localparam int ADDR_W    = 17;
   localparam int DATA_W    = 32;
   localparam int SIZE_W    = 2;
   localparam int PIX_W     = 20;
   localparam int COLOR_W   = 32;
   localparam int BOX_COL_W = 11;
   localparam int BOX_ROW_W = 10;
   localparam int IDX_W     = 5;
   localparam int CSR_IDX_W = 3;

   // Address arithmetic widths, derived from the address width, the geometry and the reciprocal shift
   localparam int POS_W       = ADDR_W + 3;
   localparam int COL_W       = $clog2(SOURCE_PITCH);
   localparam int ROW_W       = POS_W - COL_W + 1;
   localparam int PITCH_W     = $clog2(SOURCE_PITCH + 1);
   localparam int WID_W       = $clog2(SCREEN_WIDTH + 1);
   localparam int SCALE_W     = ROW_W + WID_W;
   localparam int BASE_W      = SCALE_W + 1;
   localparam int RECIP_SHIFT = 32;
   localparam int RECIP_W     = RECIP_SHIFT - COL_W + 1;

   // Reciprocal of the pitch; the row estimate from it is at most one low
   localparam logic [RECIP_W-1:0] ROW_RECIP =
      RECIP_W'((64'd1 << RECIP_SHIFT) / SOURCE_PITCH);

   localparam logic [BASE_W-1:0] PIXEL_LIMIT = BASE_W'(SCREEN_WIDTH * SCREEN_HEIGHT);
   localparam logic [PIX_W-1:0]  LAST_PIXEL  = PIX_W'(SCREEN_WIDTH * SCREEN_HEIGHT - 1);

   // Operation and size codes
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   localparam logic [SIZE_W-1:0] SIZE_BYTE = 2'd0;
   localparam logic [SIZE_W-1:0] SIZE_HALF = 2'd1;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SHOWN = 3'd0,
      CSR_INV0  = 3'd1,
      CSR_INV1  = 3'd2,
      CSR_LIT   = 3'd3,
      CSR_DARK  = 3'd4
   } csr_index_type;

   // Empty dirty box
   localparam logic [BOX_COL_W-1:0] BOX_LEFT_EMPTY   = '1;
   localparam logic [BOX_COL_W-1:0] BOX_RIGHT_EMPTY  = '0;
   localparam logic [BOX_ROW_W-1:0] BOX_TOP_EMPTY    = '1;
   localparam logic [BOX_ROW_W-1:0] BOX_BOTTOM_EMPTY = '0;

   typedef struct packed {
      logic               shown;
      logic               inv0;
      logic               inv1;
      logic [COLOR_W-1:0] lit;
      logic [COLOR_W-1:0] dark;
   } cfg_type;

   typedef struct packed {
      logic [BOX_COL_W-1:0] left;
      logic [BOX_COL_W-1:0] right;
      logic [BOX_ROW_W-1:0] top;
      logic [BOX_ROW_W-1:0] bottom;
   } box_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_QUOT,
      ST_PROD,
      ST_FIX,
      ST_SCALE,
      ST_CHECK,
      ST_EMIT,
      ST_CLEAR
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic ready;
      logic calc_quot;
      logic calc_prod;
      logic calc_fix;
      logic calc_scale;
      logic calc_check;
      logic emit_pixel;
      logic emit_clear;
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic req_valid;
      logic req_clear;
      logic in_range;
      logic slot_free;
      logic run_done;
   } ctrl_status_type;

endpackage

`default_nettype wire

[rtl/mfpe_req_if.sv]
// Request channel: one pixel write or clear transaction.
`default_nettype none

interface mfpe_req_if import mfpe_pkg::*;;
   logic              valid;
   logic              ready;
   logic              operation;
   logic              console;
   logic [ADDR_W-1:0] byte_address;
   logic [DATA_W-1:0] write_data;
   logic [SIZE_W-1:0] write_size;

   modport source (
      output valid, operation, console, byte_address, write_data, write_size,
      input  ready
   );
   modport sink (
      input  valid, operation, console, byte_address, write_data, write_size,
      output ready
   );
endinterface

`default_nettype wire

[rtl/mfpe_rsp_if.sv]
// Response channel: one pixel write or clear result transaction.
`default_nettype none

interface mfpe_rsp_if import mfpe_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic                 pixel_valid;
   logic                 image_console;
   logic [PIX_W-1:0]     pixel_index;
   logic [COLOR_W-1:0]   pixel_color;
   logic                 to_display;
   logic                 last_of_run;
   logic [BOX_COL_W-1:0] dirty_left;
   logic [BOX_COL_W-1:0] dirty_right;
   logic [BOX_ROW_W-1:0] dirty_top;
   logic [BOX_ROW_W-1:0] dirty_bottom;

   modport source (
      output valid, pixel_valid, image_console, pixel_index, pixel_color, to_display,
             last_of_run, dirty_left, dirty_right, dirty_top, dirty_bottom,
      input  ready
   );
   modport sink (
      input  valid, pixel_valid, image_console, pixel_index, pixel_color, to_display,
             last_of_run, dirty_left, dirty_right, dirty_top, dirty_bottom,
      output ready
   );
endinterface

`default_nettype wire

[rtl/mfpe_ctrl.sv]
// Controller state machine sequencing address arithmetic and pixel emission.
`default_nettype none

module mfpe_ctrl import mfpe_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  ctrl_status_type status,
   output ctrl_cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (status.req_valid) begin
               state_in = status.req_clear ? ST_CLEAR : ST_QUOT;
            end
         end
         ST_QUOT:  state_in = ST_PROD;
         ST_PROD:  state_in = ST_FIX;
         ST_FIX:   state_in = ST_SCALE;
         ST_SCALE: state_in = ST_CHECK;
         ST_CHECK: state_in = status.in_range ? ST_EMIT : ST_IDLE;
         ST_EMIT: begin
            if (status.slot_free && status.run_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_CLEAR: begin
            if (status.slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Commands
   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE:  cmd.ready      = 1'b1;
         ST_QUOT:  cmd.calc_quot  = 1'b1;
         ST_PROD:  cmd.calc_prod  = 1'b1;
         ST_FIX:   cmd.calc_fix   = 1'b1;
         ST_SCALE: cmd.calc_scale = 1'b1;
         ST_CHECK: cmd.calc_check = 1'b1;
         ST_EMIT:  cmd.emit_pixel = status.slot_free;
         ST_CLEAR: cmd.emit_clear = status.slot_free;
         default:  cmd = '0;
      endcase
   end

endmodule

`default_nettype wire

[rtl/mfpe_dp.sv]
// Datapath: row and column split, dirty box, pixel counter and result register.
`default_nettype none

module mfpe_dp import mfpe_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   mfpe_req_if.sink        req_chan,
   mfpe_rsp_if.source      rsp_chan,
   input  cfg_type         cfg,
   input  ctrl_cmd_type    cmd,
   output ctrl_status_type status
);

   // Captured transaction
   logic               con_ff, con_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [DATA_W-1:0]  data_ff, data_in;
   logic [IDX_W-1:0]   run_last_ff, run_last_in;

   // Address arithmetic
   logic [ROW_W-1:0]   row_est_ff, row_est_in;
   logic [POS_W-1:0]   back_ff, back_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [SCALE_W-1:0] scale_ff, scale_in;
   logic [PIX_W-1:0]   base_ff, base_in;
   logic               shown_ff, shown_in;

   // Emission
   logic [IDX_W-1:0]   idx_ff, idx_in;
   box_type            box_ff, box_in;

   // Result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_pixel_valid_ff, rsp_pixel_valid_in;
   logic                 rsp_console_ff, rsp_console_in;
   logic [PIX_W-1:0]     rsp_index_ff, rsp_index_in;
   logic [COLOR_W-1:0]   rsp_color_ff, rsp_color_in;
   logic                 rsp_display_ff, rsp_display_in;
   logic                 rsp_last_ff, rsp_last_in;
   box_type              rsp_box_ff, rsp_box_in;

   logic                         take;
   logic [POS_W+RECIP_W-1:0]     quot_prod;
   logic [ROW_W+PITCH_W-1:0]     back_prod;
   logic [POS_W-1:0]             rem;
   logic                         rem_wrap;
   logic [BASE_W-1:0]            base_full;
   logic                         in_range;
   logic                         shown_now;
   logic [BOX_COL_W-1:0]         col_box;
   logic [BOX_COL_W-1:0]         col_end;
   logic [BOX_ROW_W-1:0]         row_box;
   logic [BOX_ROW_W-1:0]         row_end;
   logic [PIX_W-1:0]             pix;
   logic                         run_done;
   logic                         lit;
   logic                         load;
   logic                         slot_free;

   assign req_chan.ready = cmd.ready;
   assign take           = req_chan.valid && cmd.ready;

   // Row estimate by reciprocal, product back, one correction step
   assign quot_prod = {{RECIP_W{1'b0}}, pos_ff} * {{POS_W{1'b0}}, ROW_RECIP};
   assign back_prod = (ROW_W + PITCH_W)'(row_est_ff) * (ROW_W + PITCH_W)'(SOURCE_PITCH);
   assign rem       = pos_ff - back_ff;
   assign rem_wrap  = rem >= POS_W'(SOURCE_PITCH);

   // Base index and screen check
   assign base_full = BASE_W'(scale_ff) + BASE_W'(col_ff);
   assign in_range  = base_full < PIXEL_LIMIT;
   assign shown_now = con_ff == cfg.shown;
   assign col_box   = BOX_COL_W'(col_ff);
   assign col_end   = col_box + BOX_COL_W'(run_last_ff) + BOX_COL_W'(1);
   assign row_box   = BOX_ROW_W'(row_ff);
   assign row_end   = row_box + BOX_ROW_W'(1);

   // Current pixel of the run
   assign pix      = base_ff + PIX_W'(idx_ff);
   assign run_done = (idx_ff == run_last_ff) || (pix == LAST_PIXEL);
   assign lit      = data_ff[idx_ff] == (con_ff ? cfg.inv1 : cfg.inv0);

   assign slot_free = !rsp_valid_ff || rsp_chan.ready;
   assign load      = cmd.emit_pixel || cmd.emit_clear;

   always_comb begin
      con_in      = con_ff;
      pos_in      = pos_ff;
      data_in     = data_ff;
      run_last_in = run_last_ff;
      idx_in      = idx_ff;
      if (take) begin
         con_in  = req_chan.console;
         pos_in  = {req_chan.byte_address, 3'b000};
         data_in = req_chan.write_data;
         idx_in  = '0;
         case (req_chan.write_size)
            SIZE_BYTE: run_last_in = IDX_W'(7);
            SIZE_HALF: run_last_in = IDX_W'(15);
            default:   run_last_in = IDX_W'(31);
         endcase
      end else if (cmd.emit_pixel) begin
         idx_in = idx_ff + IDX_W'(1);
      end
   end

   always_comb begin
      row_est_in = cmd.calc_quot  ? quot_prod[RECIP_SHIFT +: ROW_W] : row_est_ff;
      back_in    = cmd.calc_prod  ? POS_W'(back_prod) : back_ff;
      row_in     = cmd.calc_fix   ? row_est_ff + ROW_W'(rem_wrap) : row_ff;
      col_in     = col_ff;
      if (cmd.calc_fix) begin
         col_in = COL_W'(rem_wrap ? rem - POS_W'(SOURCE_PITCH) : rem);
      end
      scale_in   = cmd.calc_scale ? SCALE_W'(row_ff) * SCALE_W'(SCREEN_WIDTH) : scale_ff;
      base_in    = cmd.calc_check ? PIX_W'(base_full) : base_ff;
      shown_in   = cmd.calc_check ? shown_now : shown_ff;
   end

   // Dirty box: widened by a visible write, emptied by a clear
   always_comb begin
      box_in = box_ff;
      if (cmd.emit_clear) begin
         box_in = '{BOX_LEFT_EMPTY, BOX_RIGHT_EMPTY, BOX_TOP_EMPTY, BOX_BOTTOM_EMPTY};
      end else if (cmd.calc_check && in_range && shown_now) begin
         if (col_box < box_ff.left) begin
            box_in.left = col_box;
         end
         if (col_end > box_ff.right) begin
            box_in.right = col_end;
         end
         if (row_box < box_ff.top) begin
            box_in.top = row_box;
         end
         if (row_end > box_ff.bottom) begin
            box_in.bottom = row_end;
         end
      end
   end

   // Result register
   always_comb begin
      rsp_valid_in       = rsp_valid_ff && !rsp_chan.ready;
      rsp_pixel_valid_in = rsp_pixel_valid_ff;
      rsp_console_in     = rsp_console_ff;
      rsp_index_in       = rsp_index_ff;
      rsp_color_in       = rsp_color_ff;
      rsp_display_in     = rsp_display_ff;
      rsp_last_in        = rsp_last_ff;
      rsp_box_in         = rsp_box_ff;
      if (cmd.emit_pixel) begin
         rsp_valid_in       = 1'b1;
         rsp_pixel_valid_in = 1'b1;
         rsp_console_in     = con_ff;
         rsp_index_in       = pix;
         rsp_color_in       = lit ? cfg.lit : cfg.dark;
         rsp_display_in     = shown_ff;
         rsp_last_in        = run_done;
         rsp_box_in         = box_ff;
      end else if (cmd.emit_clear) begin
         rsp_valid_in       = 1'b1;
         rsp_pixel_valid_in = 1'b0;
         rsp_console_in     = 1'b0;
         rsp_index_in       = '0;
         rsp_color_in       = '0;
         rsp_display_in     = 1'b0;
         rsp_last_in        = 1'b1;
         rsp_box_in         = box_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         box_ff       <= '{BOX_LEFT_EMPTY, BOX_RIGHT_EMPTY, BOX_TOP_EMPTY, BOX_BOTTOM_EMPTY};
         rsp_valid_ff <= 1'b0;
      end else begin
         box_ff       <= box_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      con_ff             <= con_in;
      pos_ff             <= pos_in;
      data_ff            <= data_in;
      run_last_ff        <= run_last_in;
      row_est_ff         <= row_est_in;
      back_ff            <= back_in;
      row_ff             <= row_in;
      col_ff             <= col_in;
      scale_ff           <= scale_in;
      base_ff            <= base_in;
      shown_ff           <= shown_in;
      idx_ff             <= idx_in;
      rsp_pixel_valid_ff <= rsp_pixel_valid_in;
      rsp_console_ff     <= rsp_console_in;
      rsp_index_ff       <= rsp_index_in;
      rsp_color_ff       <= rsp_color_in;
      rsp_display_ff     <= rsp_display_in;
      rsp_last_ff        <= rsp_last_in;
      rsp_box_ff         <= rsp_box_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.pixel_valid   = rsp_pixel_valid_ff;
   assign rsp_chan.image_console = rsp_console_ff;
   assign rsp_chan.pixel_index   = rsp_index_ff;
   assign rsp_chan.pixel_color   = rsp_color_ff;
   assign rsp_chan.to_display    = rsp_display_ff;
   assign rsp_chan.last_of_run   = rsp_last_ff;
   assign rsp_chan.dirty_left    = rsp_box_ff.left;
   assign rsp_chan.dirty_right   = rsp_box_ff.right;
   assign rsp_chan.dirty_top     = rsp_box_ff.top;
   assign rsp_chan.dirty_bottom  = rsp_box_ff.bottom;

   assign status.req_valid = req_chan.valid;
   assign status.req_clear = req_chan.operation == OP_CLEAR;
   assign status.in_range  = in_range;
   assign status.slot_free = slot_free;
   assign status.run_done  = run_done;

   // A result is only loaded when the output register is free or draining
   a_emit_slot: assert property (@(posedge clock) disable iff (reset)
      load |-> slot_free)
      else $error("result loaded over an untaken transaction");

   // Pixel results never point past the screen
   a_index_on_screen: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_pixel_valid_ff) |-> (rsp_index_ff <= LAST_PIXEL))
      else $error("pixel index beyond the screen");

   // A visible in-range write leaves a non-empty box
   a_box_widened: assert property (@(posedge clock) disable iff (reset)
      (cmd.calc_check && in_range && shown_now) |=>
         ((box_ff.left < box_ff.right) && (box_ff.top < box_ff.bottom)))
      else $error("dirty box empty after a visible write");

endmodule

`default_nettype wire

[rtl/mono_framebuffer_pixel_expander.sv]
// Top level of the mono framebuffer pixel expander with configuration registers.
`default_nettype none

// Expands a write of 8, 16 or 32 one-bit pixels into one 32-bit colour
// transaction per pixel, least significant bit first, and keeps a dirty box of
// the shown console. A write transaction is taken when the block is idle; the
// row and column split then runs through reciprocal multiply, product back,
// correction, row scaling and screen check, and the pixels leave the single
// result register at one per cycle while the response channel takes them; a
// write whose base lies off the screen emits none, and a run stops at the last
// pixel of the screen. A clear emits a single result with an empty dirty box.
// Backpressure stretches the pixel phase; configuration writes are registered.
module mono_framebuffer_pixel_expander import mfpe_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   mfpe_req_if.sink             req_chan,
   mfpe_rsp_if.source           rsp_chan,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [COLOR_W-1:0]   csr_write_data
);

   cfg_type         cfg_ff;
   cfg_type         cfg_in;
   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   // Configuration register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_SHOWN: cfg_in.shown = csr_write_data[0];
            CSR_INV0:  cfg_in.inv0  = csr_write_data[0];
            CSR_INV1:  cfg_in.inv1  = csr_write_data[0];
            CSR_LIT:   cfg_in.lit   = csr_write_data;
            CSR_DARK:  cfg_in.dark  = csr_write_data;
            default:   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{1'b0, 1'b0, 1'b0, '1, '0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mfpe_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   mfpe_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .cfg      (cfg_ff),
      .cmd      (cmd),
      .status   (status)
   );

endmodule

`default_nettype wire
